/* rtl/tgbm_pkg.sv */
// shared types and constants for the touch gesture button mapper
package tgbm_pkg;
  localparam int MAX_FINGERS = 8;
  localparam int COORD_BITS = 16;

  typedef enum logic [2:0] {
    OP_DOWN  = 3'd0,
    OP_MOVE  = 3'd1,
    OP_UP    = 3'd2,
    OP_KDOWN = 3'd3,
    OP_KUP   = 3'd4,
    OP_PAD   = 3'd5,
    OP_TICK  = 3'd6,
    OP_TICK7 = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    REG_SCALE_X  = 3'd0,
    REG_SCALE_Y  = 3'd1,
    REG_DEADZONE = 3'd2,
    REG_RADIUS   = 3'd3,
    REG_TAP_MAX  = 3'd4,
    REG_TAP_HOLD = 3'd5
  } reg_t;

  localparam logic [12:0] SCALE_X_RST = 13'd640;
  localparam logic [12:0] SCALE_Y_RST = 13'd480;
  localparam logic [7:0] DEADZONE_RST = 8'd12;
  localparam logic [7:0] RADIUS_RST = 8'd18;
  localparam logic [15:0] TAP_MAX_RST = 16'd400;
  localparam logic [15:0] TAP_HOLD_RST = 16'd100;

  localparam int B_UP = 0;
  localparam int B_DOWN = 1;
  localparam int B_LEFT = 2;
  localparam int B_RIGHT = 3;
  localparam int B_CONFIRM = 4;
  localparam int B_CANCEL = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULX,
    ST_MULY,
    ST_SQX,
    ST_SQY,
    ST_APPLY,
    ST_DRAG,
    ST_OUT
  } state_t;
endpackage

/* rtl/tgbm_front.sv */
// input queue stage: holds up to two accepted events and maps opcode 7 onto OP_TICK
module tgbm_front #(
  parameter int CoordBits = tgbm_pkg::COORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           opcode,
  input  logic [31:0]          finger_id,
  input  logic [CoordBits-1:0] pos_x,
  input  logic [CoordBits-1:0] pos_y,
  input  logic [3:0]           button_index,
  input  logic [9:0]           pad_buttons,
  input  logic [31:0]          now_ms,
  output logic                 ev_valid,
  input  logic                 ev_take,
  output tgbm_pkg::op_t        ev_op,
  output logic [31:0]          ev_id,
  output logic [CoordBits-1:0] ev_x,
  output logic [CoordBits-1:0] ev_y,
  output logic [3:0]           ev_bi,
  output logic [9:0]           ev_pad,
  output logic [31:0]          ev_now
);
  // two-entry queue
  logic [1:0] cnt;
  logic       wp, rp;
  tgbm_pkg::op_t        q_op [2];
  logic [31:0]          q_id [2];
  logic [CoordBits-1:0] q_x [2];
  logic [CoordBits-1:0] q_y [2];
  logic [3:0]           q_bi [2];
  logic [9:0]           q_pad [2];
  logic [31:0]          q_now [2];
  logic do_push, do_pop;

  assign full = (cnt == 2'd2);
  assign ev_valid = (cnt != 2'd0);
  assign do_push = push && !full;
  assign do_pop = ev_take && ev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp <= 1'b0;
      rp <= 1'b0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_op[wp] <= tgbm_pkg::op_t'(opcode);
      q_id[wp] <= finger_id;
      q_x[wp] <= pos_x;
      q_y[wp] <= pos_y;
      q_bi[wp] <= button_index;
      q_pad[wp] <= pad_buttons;
      q_now[wp] <= now_ms;
    end
  end

  always_comb begin
    ev_op = q_op[rp];
    if (ev_op == tgbm_pkg::OP_TICK7) ev_op = tgbm_pkg::OP_TICK;
    ev_id = q_id[rp];
    ev_x = q_x[rp];
    ev_y = q_y[rp];
    ev_bi = q_bi[rp];
    ev_pad = q_pad[rp];
    ev_now = q_now[rp];
  end
endmodule

/* rtl/tgbm_back.sv */
// event execution: finger table, tap and drag evaluation, result register
module tgbm_back #(
  parameter int MaxFingers = tgbm_pkg::MAX_FINGERS,
  parameter int CoordBits = tgbm_pkg::COORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ev_valid,
  output logic                 ev_take,
  input  tgbm_pkg::op_t        ev_op,
  input  logic [31:0]          ev_id,
  input  logic [CoordBits-1:0] ev_x,
  input  logic [CoordBits-1:0] ev_y,
  input  logic [3:0]           ev_bi,
  input  logic [9:0]           ev_pad,
  input  logic [31:0]          ev_now,
  input  logic [12:0]          scale_x,
  input  logic [12:0]          scale_y,
  input  logic [7:0]           deadzone_px,
  input  logic [7:0]           tap_radius_px,
  input  logic [15:0]          tap_max_ms,
  input  logic [15:0]          tap_hold_ms,
  output logic                 empty,
  input  logic                 pop,
  output logic [9:0]           buttons,
  output logic [3:0]           fingers_down
);
  localparam int SW = $clog2(MaxFingers);
  localparam int CW = $clog2(MaxFingers + 1);
  localparam int DW = CoordBits + 1;
  localparam int PW = DW + 13;
  localparam int LW = 8 + CoordBits;
  localparam int QW = 2 * LW + 1;

  logic [MaxFingers-1:0] used;
  logic [31:0]           sid [MaxFingers];
  logic [CoordBits-1:0]  ox [MaxFingers];
  logic [CoordBits-1:0]  oy [MaxFingers];
  logic [CoordBits-1:0]  cx [MaxFingers];
  logic [CoordBits-1:0]  cy [MaxFingers];
  logic [SW-1:0]         sord [MaxFingers];
  logic [31:0]           dtime [MaxFingers];
  logic [9:0]            key_held, pad_held;
  logic                  tap_active;
  logic [31:0]           tap_start;

  tgbm_pkg::state_t state, state_next;
  logic [SW-1:0] slot;         // slot chosen by the lookup
  logic          hit;
  logic signed [PW-1:0] px, py;
  logic [QW-1:0] sq_sum;
  logic          tap_ok;

  // lookups over the table
  logic [MaxFingers-1:0] id_match, prim_match;
  logic [SW-1:0] id_slot, free_slot, prim_slot;
  logic          id_hit, free_hit, prim_hit;
  logic [CW-1:0] n_used;

  always_comb begin
    id_slot = '0; free_slot = '0; prim_slot = '0;
    id_hit = 1'b0; free_hit = 1'b0; prim_hit = 1'b0;
    n_used = '0;
    for (int i = MaxFingers - 1; i >= 0; i--) begin
      id_match[i] = used[i] && (sid[i] == ev_id);
      prim_match[i] = used[i] && (sord[i] == '0);
      if (id_match[i]) begin id_slot = SW'(i); id_hit = 1'b1; end
      if (!used[i]) begin free_slot = SW'(i); free_hit = 1'b1; end
      if (prim_match[i]) begin prim_slot = SW'(i); prim_hit = 1'b1; end
    end
    for (int i = 0; i < MaxFingers; i++) n_used = n_used + CW'(used[i]);
  end

  // multiplications: drag difference times scale, then squares
  logic [12:0] sx_eff, sy_eff;
  assign sx_eff = (scale_x == '0) ? 13'd640 : scale_x;
  assign sy_eff = (scale_y == '0) ? 13'd480 : scale_y;

  logic signed [DW-1:0] dx, dy;
  assign dx = $signed({1'b0, cx[slot]}) - $signed({1'b0, ox[slot]});
  assign dy = $signed({1'b0, cy[slot]}) - $signed({1'b0, oy[slot]});

  logic [PW-1:0] ax, ay;
  assign ax = px[PW-1] ? PW'(-px) : PW'(px);
  assign ay = py[PW-1] ? PW'(-py) : PW'(py);
  logic [LW-1:0] lim;
  assign lim = {tap_radius_px, {CoordBits{1'b0}}};
  logic [LW-1:0] ax_n, ay_n;
  assign ax_n = ax[LW-1:0];
  assign ay_n = ay[LW-1:0];
  logic too_far;
  assign too_far = (ax >= PW'(lim)) || (ay >= PW'(lim));

  logic signed [PW-1:0] dz;
  assign dz = $signed(PW'({deadzone_px, {CoordBits{1'b0}}}));

  logic [31:0] held_for, since_tap;
  assign held_for = ev_now - dtime[slot];
  assign since_tap = ev_now - tap_start;

  logic is_up;
  assign is_up = (ev_op == tgbm_pkg::OP_UP);

  // combined mask for the result register
  logic [9:0] out_mask;
  always_comb begin
    out_mask = key_held | pad_held;
    if (tap_active) out_mask[tgbm_pkg::B_CONFIRM] = 1'b1;
    if (hit) begin
      if (px < -dz) out_mask[tgbm_pkg::B_LEFT] = 1'b1;
      if (px > dz) out_mask[tgbm_pkg::B_RIGHT] = 1'b1;
      if (py < -dz) out_mask[tgbm_pkg::B_UP] = 1'b1;
      if (py > dz) out_mask[tgbm_pkg::B_DOWN] = 1'b1;
    end
    if (n_used >= CW'(2)) out_mask[tgbm_pkg::B_CANCEL] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tgbm_pkg::ST_IDLE;
      used <= '0;
      key_held <= '0;
      pad_held <= '0;
      tap_active <= 1'b0;
      tap_start <= '0;
      empty <= 1'b1;
    end else begin
      state <= state_next;
      if (!empty && pop) empty <= 1'b1;
      case (state)
        tgbm_pkg::ST_IDLE: begin
          if (ev_valid && empty) begin
            slot <= is_up ? id_slot : prim_slot;
            hit <= is_up ? id_hit : prim_hit;
            tap_ok <= 1'b0;
          end
        end
        tgbm_pkg::ST_MULX: px <= PW'(dx) * PW'($signed({1'b0, sx_eff}));
        tgbm_pkg::ST_MULY: py <= PW'(dy) * PW'($signed({1'b0, sy_eff}));
        tgbm_pkg::ST_SQX: sq_sum <= QW'(ax_n) * QW'(ax_n);
        tgbm_pkg::ST_SQY: begin
          sq_sum <= sq_sum + QW'(ay_n) * QW'(ay_n);
        end
        tgbm_pkg::ST_APPLY: begin
          case (ev_op)
            tgbm_pkg::OP_DOWN: begin
              if (!id_hit && free_hit) begin
                used[free_slot] <= 1'b1;
                sid[free_slot] <= ev_id;
                ox[free_slot] <= ev_x; cx[free_slot] <= ev_x;
                oy[free_slot] <= ev_y; cy[free_slot] <= ev_y;
                sord[free_slot] <= SW'(n_used);
                dtime[free_slot] <= ev_now;
              end
            end
            tgbm_pkg::OP_MOVE: begin
              if (id_hit) begin
                cx[id_slot] <= ev_x;
                cy[id_slot] <= ev_y;
              end
            end
            tgbm_pkg::OP_UP: begin
              if (hit) begin
                used[slot] <= 1'b0;
                if (sord[slot] == '0 && held_for < {16'd0, tap_max_ms} && !too_far
                    && sq_sum < QW'(lim) * QW'(lim)) begin
                  tap_ok <= 1'b1;
                end
              end
            end
            tgbm_pkg::OP_KDOWN: if (ev_bi <= 4'd9) key_held[ev_bi] <= 1'b1;
            tgbm_pkg::OP_KUP: if (ev_bi <= 4'd9) key_held[ev_bi] <= 1'b0;
            tgbm_pkg::OP_PAD: pad_held <= ev_pad;
            default: ;
          endcase
        end
        tgbm_pkg::ST_DRAG: begin
          // tap latch then expiry, both with this event's time
          if (tap_ok) begin
            tap_start <= ev_now;
            tap_active <= 1'b1;
          end else if (tap_active && since_tap > {16'd0, tap_hold_ms}) begin
            tap_active <= 1'b0;
          end
          slot <= prim_slot;
          hit <= prim_hit;
        end
        tgbm_pkg::ST_OUT: begin
          buttons <= out_mask;
          fingers_down <= 4'(n_used);
          empty <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // after DRAG the products are recomputed for the primary: loop once more
  logic second;
  always_ff @(posedge clk) begin
    if (rst) second <= 1'b0;
    else if (state == tgbm_pkg::ST_IDLE) second <= 1'b0;
    else if (state == tgbm_pkg::ST_DRAG) second <= 1'b1;
  end

  always_comb begin
    state_next = state;
    ev_take = 1'b0;
    case (state)
      tgbm_pkg::ST_IDLE: if (ev_valid && empty) state_next = tgbm_pkg::ST_MULX;
      tgbm_pkg::ST_MULX: state_next = tgbm_pkg::ST_MULY;
      tgbm_pkg::ST_MULY: state_next = second ? tgbm_pkg::ST_OUT : tgbm_pkg::ST_SQX;
      tgbm_pkg::ST_SQX: state_next = tgbm_pkg::ST_SQY;
      tgbm_pkg::ST_SQY: state_next = tgbm_pkg::ST_APPLY;
      tgbm_pkg::ST_APPLY: state_next = tgbm_pkg::ST_DRAG;
      tgbm_pkg::ST_DRAG: state_next = tgbm_pkg::ST_MULX;
      tgbm_pkg::ST_OUT: begin
        ev_take = 1'b1;
        state_next = tgbm_pkg::ST_IDLE;
      end
      default: state_next = tgbm_pkg::ST_IDLE;
    endcase
  end
endmodule

/* rtl/touch_gesture_button_mapper.sv */
// top level of the touch gesture button mapper
// Events enter through a two-entry input queue (push/full) and are executed
// one at a time by a sequencer that forms the drag products d*scale and the
// tap distance squares in separate states. For each event it computes the
// products and squares for the event's finger (the released finger on an up,
// else the primary), the table update, then the products again for the
// primary finger, and the event leaves the input queue as its result lands
// in the output register. The next event starts once the output register
// has been popped, so a result waits in its register while up to two further
// events queue. Every event yields exactly one result (buttons, fingers_down).
// Configuration writes are always ready and should only be issued while no
// event is in flight; index values beyond five are ignored.
module touch_gesture_button_mapper #(
  parameter int MaxFingers = tgbm_pkg::MAX_FINGERS,
  parameter int CoordBits = tgbm_pkg::COORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // event queue side
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           opcode,
  input  logic [31:0]          finger_id,
  input  logic [CoordBits-1:0] pos_x,
  input  logic [CoordBits-1:0] pos_y,
  input  logic [3:0]           button_index,
  input  logic [9:0]           pad_buttons,
  input  logic [31:0]          now_ms,
  // result queue side
  output logic                 empty,
  input  logic                 pop,
  output logic [9:0]           buttons,
  output logic [3:0]           fingers_down,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  logic [12:0] scale_x, scale_y;
  logic [7:0]  deadzone_px, tap_radius_px;
  logic [15:0] tap_max_ms, tap_hold_ms;

  assign cfg_ready = 1'b1;

  // config registers, one transaction per write
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x <= tgbm_pkg::SCALE_X_RST;
      scale_y <= tgbm_pkg::SCALE_Y_RST;
      deadzone_px <= tgbm_pkg::DEADZONE_RST;
      tap_radius_px <= tgbm_pkg::RADIUS_RST;
      tap_max_ms <= tgbm_pkg::TAP_MAX_RST;
      tap_hold_ms <= tgbm_pkg::TAP_HOLD_RST;
    end else if (cfg_valid) begin
      case (tgbm_pkg::reg_t'(cfg_index))
        tgbm_pkg::REG_SCALE_X: scale_x <= cfg_data[12:0];
        tgbm_pkg::REG_SCALE_Y: scale_y <= cfg_data[12:0];
        tgbm_pkg::REG_DEADZONE: deadzone_px <= cfg_data[7:0];
        tgbm_pkg::REG_RADIUS: tap_radius_px <= cfg_data[7:0];
        tgbm_pkg::REG_TAP_MAX: tap_max_ms <= cfg_data;
        tgbm_pkg::REG_TAP_HOLD: tap_hold_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                 ev_valid, ev_take;
  tgbm_pkg::op_t        ev_op;
  logic [31:0]          ev_id, ev_now;
  logic [CoordBits-1:0] ev_x, ev_y;
  logic [3:0]           ev_bi;
  logic [9:0]           ev_pad;

  // front: event queue and opcode cleanup
  tgbm_front #(.CoordBits(CoordBits)) u_front (
    .clk, .rst, .push, .full, .opcode, .finger_id, .pos_x, .pos_y,
    .button_index, .pad_buttons, .now_ms,
    .ev_valid, .ev_take, .ev_op, .ev_id, .ev_x, .ev_y, .ev_bi, .ev_pad, .ev_now
  );

  // back: table, tap, drag and result register
  tgbm_back #(.MaxFingers(MaxFingers), .CoordBits(CoordBits)) u_back (
    .clk, .rst, .ev_valid, .ev_take, .ev_op, .ev_id, .ev_x, .ev_y, .ev_bi,
    .ev_pad, .ev_now, .scale_x, .scale_y, .deadzone_px, .tap_radius_px,
    .tap_max_ms, .tap_hold_ms, .empty, .pop, .buttons, .fingers_down
  );
endmodule

/* rtl/tgbm_checker.sv */
// port-level checks for the touch gesture button mapper
module tgbm_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [9:0] buttons,
  input logic [3:0] fingers_down
);
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> fingers_down <= 4'd8) else $error("finger count out of range");
  a_cancel: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (buttons[5] == (fingers_down >= 4'd2)) || buttons[5])
    else $error("cancel missing");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(buttons)) else $error("result dropped");
endmodule

bind touch_gesture_button_mapper tgbm_checker u_tgbm_checker (
  .clk, .rst, .empty, .pop, .buttons, .fingers_down
);
